// File: hdl/se2ti_pkg.sv
package se2ti_pkg;

    // Field widths of the twist and pose words.
    localparam int WORD_BITS     = 32;
    localparam int FRAC_BITS_DEF = 16;

    // Fraction bits of the internal sine and cosine values.
    localparam int TRIG_BITS = 30;

    // Register stages of the sine/cosine unit and of the divider.
    localparam int SC_LAT   = 12;
    localparam int DIV_LAT  = WORD_BITS + 5;

    // Total stages from the input register to the last divider register.
    localparam int PIPE_LAT = 4 + SC_LAT + DIV_LAT;

    // Input item: planar twist.
    typedef struct packed {
        logic signed [WORD_BITS-1:0] rate_angular;
        logic signed [WORD_BITS-1:0] rate_x;
        logic signed [WORD_BITS-1:0] rate_y;
    } twist_t;

    // Result item: displacement pose.
    typedef struct packed {
        logic signed [WORD_BITS-1:0] disp_x;
        logic signed [WORD_BITS-1:0] disp_y;
        logic signed [WORD_BITS-1:0] disp_angle;
    } pose_t;

endpackage

// File: hdl/se2ti_sincos.sv
module se2ti_sincos (
    input  logic               clk,
    input  logic               en,
    input  logic        [31:0] phase,
    output logic signed [31:0] sin_q30,
    output logic signed [31:0] cos_q30
);
    import se2ti_pkg::*;

    localparam int RECIP_SHIFT = 37;
    localparam int RECIP_BITS  = 35;
    localparam int STEPS       = 3;

    localparam logic [30:0] TRIG_ONE    = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'h6487_ED51;

    // Reciprocals for exact truncating division of values below 2^30.
    localparam logic [RECIP_BITS-1:0] RECIP_72 =
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd71) / 64'd72);
    localparam logic [RECIP_BITS-1:0] RECIP_42 =
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd41) / 64'd42);
    localparam logic [RECIP_BITS-1:0] RECIP_20 =
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd19) / 64'd20);
    localparam logic [RECIP_BITS-1:0] RECIP_6 =
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd5) / 64'd6);
    localparam logic [RECIP_BITS-1:0] RECIP_90 =
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd89) / 64'd90);
    localparam logic [RECIP_BITS-1:0] RECIP_56 =
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd55) / 64'd56);
    localparam logic [RECIP_BITS-1:0] RECIP_30 =
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd29) / 64'd30);
    localparam logic [RECIP_BITS-1:0] RECIP_12 =
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd11) / 64'd12);

    localparam logic [RECIP_BITS-1:0] SIN_RECIP [STEPS] = '{RECIP_42, RECIP_20, RECIP_6};
    localparam logic [RECIP_BITS-1:0] COS_RECIP [STEPS] = '{RECIP_56, RECIP_30, RECIP_12};

    typedef struct packed {
        logic [1:0]  quad;
        logic        neg;
        logic [29:0] a;
        logic [29:0] a2;
        logic [30:0] ts;
        logic [30:0] tc;
        logic [29:0] ps;
        logic [29:0] pc;
    } sc_stage_t;

    // Truncating division by a small constant through its reciprocal.
    function automatic logic [29:0] div_const(input logic [29:0] x,
                                              input logic [RECIP_BITS-1:0] m);
        logic [RECIP_SHIFT+29:0] p;
        p = (RECIP_SHIFT+30)'(x) * (RECIP_SHIFT+30)'(m);
        return p[RECIP_SHIFT+29:RECIP_SHIFT];
    endfunction

    sc_stage_t          st_reg  [1:SC_LAT-1];
    sc_stage_t          st_next [1:SC_LAT-1];
    logic signed [31:0] sin_reg, sin_next;
    logic signed [31:0] cos_reg, cos_next;

    // Next value of every stage.
    always_comb
    begin
        logic [31:0]        pr;
        logic [1:0]         qv;
        logic [31:0]        d;
        logic [31:0]        u;
        logic [60:0]        prod;
        logic [59:0]        sq;
        logic [30:0]        cv;
        logic signed [31:0] s_v;
        logic signed [31:0] c_v;

        // Quadrant and residual of the phase.
        pr = phase + 32'h2000_0000;
        qv = pr[31:30];
        d  = phase - {qv, 30'd0};
        u  = d[31] ? (32'd0 - d) : d;
        st_next[1]      = '0;
        st_next[1].quad = qv;
        st_next[1].neg  = d[31];
        st_next[1].a    = u[29:0];

        // Residual in turns to radians.
        st_next[2]   = st_reg[1];
        prod         = 61'(st_reg[1].a) * 61'(HALF_PI_Q30) + 61'(32'h2000_0000);
        st_next[2].a = prod[59:30];

        // Square of the angle.
        st_next[3]    = st_reg[2];
        sq            = 60'(st_reg[2].a) * 60'(st_reg[2].a);
        st_next[3].a2 = sq[59:30];

        // First Horner terms.
        st_next[4]    = st_reg[3];
        st_next[4].ts = TRIG_ONE - {1'b0, div_const(st_reg[3].a2, RECIP_72)};
        st_next[4].tc = TRIG_ONE - {1'b0, div_const(st_reg[3].a2, RECIP_90)};

        // Remaining Horner steps: a multiply stage, then a divide stage.
        for (int j = 0; j < STEPS; j++)
        begin
            st_next[5+2*j]    = st_reg[4+2*j];
            prod              = 61'(st_reg[4+2*j].a2) * 61'(st_reg[4+2*j].ts);
            st_next[5+2*j].ps = prod[59:30];
            prod              = 61'(st_reg[4+2*j].a2) * 61'(st_reg[4+2*j].tc);
            st_next[5+2*j].pc = prod[59:30];

            st_next[6+2*j]    = st_reg[5+2*j];
            st_next[6+2*j].ts = TRIG_ONE - {1'b0, div_const(st_reg[5+2*j].ps, SIN_RECIP[j])};
            st_next[6+2*j].tc = TRIG_ONE - {1'b0, div_const(st_reg[5+2*j].pc, COS_RECIP[j])};
        end

        // Final products of the two series.
        st_next[11]    = st_reg[10];
        prod           = 61'(st_reg[10].a) * 61'(st_reg[10].ts);
        st_next[11].ps = prod[59:30];
        prod           = 61'(st_reg[10].a2) * 61'(st_reg[10].tc);
        st_next[11].pc = prod[59:30];

        // Sign, cosine tail and quadrant rotation.
        cv  = TRIG_ONE - {2'b00, st_reg[11].pc[29:1]};
        s_v = {2'b00, st_reg[11].ps};
        if (st_reg[11].neg)
        begin
            s_v = -s_v;
        end
        c_v = {1'b0, cv};
        unique case (st_reg[11].quad)
            2'd0:
            begin
                sin_next = s_v;
                cos_next = c_v;
            end
            2'd1:
            begin
                sin_next = c_v;
                cos_next = -s_v;
            end
            2'd2:
            begin
                sin_next = -s_v;
                cos_next = -c_v;
            end
            2'd3:
            begin
                sin_next = -c_v;
                cos_next = s_v;
            end
        endcase
    end

    // Stage registers, held while the pipeline stalls.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 1; k < SC_LAT; k++)
            begin
                st_reg[k] <= st_next[k];
            end
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    // The last stage holds the rotated results.
    assign sin_q30 = sin_reg;
    assign cos_q30 = cos_reg;

endmodule

// File: hdl/se2ti_div.sv
module se2ti_div #(
    parameter int FRAC_BITS = se2ti_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic                           [63:0] num,
    input  logic signed [se2ti_pkg::WORD_BITS-1:0] rate,
    output logic signed [se2ti_pkg::WORD_BITS-1:0] quo
);
    import se2ti_pkg::*;

    localparam int QB    = WORD_BITS + 1;
    localparam int SHIFT = TRIG_BITS - FRAC_BITS;

    localparam logic [QB-1:0] MAX_POS = QB'((64'd1 << (WORD_BITS - 1)) - 64'd1);
    localparam logic [QB-1:0] MAX_NEG = QB'(64'd1 << (WORD_BITS - 1));

    typedef struct packed {
        logic          nneg;
        logic          wneg;
        logic          dz;
        logic          ovf;
        logic [63:0]   den;
        logic [63:0]   rem;
        logic [QB-1:0] low;
        logic [QB-1:0] quo;
    } it_stage_t;

    logic        nneg_a_reg, wneg_a_reg;
    logic [63:0] nm_a_reg, den_a_reg;
    logic        nneg_b_reg, wneg_b_reg;
    logic [63:0] dvd_b_reg, den_b_reg;

    it_stage_t   it_reg  [0:QB];
    it_stage_t   it_next [0:QB];

    logic signed [WORD_BITS-1:0] quo_reg, quo_next;

    logic [63:0] wext;
    logic [63:0] wmag;
    logic [63:0] nmag;

    // Magnitudes and scaled divisor.
    assign wext = {{(64-WORD_BITS){rate[WORD_BITS-1]}}, rate};
    assign wmag = rate[WORD_BITS-1] ? (64'd0 - wext) : wext;
    assign nmag = num[63] ? (64'd0 - num) : num;

    // Iteration stages, one quotient bit each.
    always_comb
    begin
        logic [64:0] r2;
        logic [64:0] diff;
        logic        ge;
        logic [63:0] hi;
        logic [QB-1:0] q;
        logic          big;
        logic [QB-1:0] mag;

        big = 1'b0;
        mag = '0;

        hi              = dvd_b_reg >> QB;
        it_next[0].nneg = nneg_b_reg;
        it_next[0].wneg = wneg_b_reg;
        it_next[0].dz   = (den_b_reg == 64'd0);
        it_next[0].ovf  = (hi >= den_b_reg);
        it_next[0].den  = den_b_reg;
        it_next[0].rem  = hi;
        it_next[0].low  = dvd_b_reg[QB-1:0];
        it_next[0].quo  = '0;

        for (int k = 0; k < QB; k++)
        begin
            r2   = {it_reg[k].rem, it_reg[k].low[QB-1]};
            diff = r2 - {1'b0, it_reg[k].den};
            ge   = (r2 >= {1'b0, it_reg[k].den});
            it_next[k+1]     = it_reg[k];
            it_next[k+1].rem = ge ? diff[63:0] : r2[63:0];
            it_next[k+1].low = it_reg[k].low << 1;
            it_next[k+1].quo = {it_reg[k].quo[QB-2:0], ge};
        end

        // Saturation and sign of the rounded quotient; a zero divisor gives zero.
        q = it_reg[QB].quo;
        if (it_reg[QB].dz)
        begin
            quo_next = '0;
        end
        else if (it_reg[QB].nneg == it_reg[QB].wneg)
        begin
            big      = it_reg[QB].ovf || (q > MAX_POS);
            mag      = big ? MAX_POS : q;
            quo_next = mag[WORD_BITS-1:0];
        end
        else
        begin
            big      = it_reg[QB].ovf || (q > MAX_NEG);
            mag      = big ? MAX_NEG : q;
            quo_next = WORD_BITS'(-mag);
        end
    end

    // Stage registers, held while the pipeline stalls.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nneg_a_reg <= num[63];
            wneg_a_reg <= rate[WORD_BITS-1];
            nm_a_reg   <= nmag;
            den_a_reg  <= wmag << SHIFT;

            nneg_b_reg <= nneg_a_reg;
            wneg_b_reg <= wneg_a_reg;
            dvd_b_reg  <= nm_a_reg + (den_a_reg >> 1);
            den_b_reg  <= den_a_reg;

            for (int k = 0; k <= QB; k++)
            begin
                it_reg[k] <= it_next[k];
            end
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

// File: hdl/se2_twist_integrator.sv
// Planar twist integrator: exponential map of (w, vx, vy) held for unit time.
//
// Input channel twist (twist_valid / twist_ready) carries one twist_t per
// transfer; output channel pose (pose_valid / pose_ready) carries one pose_t
// per transfer, exactly one pose for each twist, in order.
//
// Each twist passes through PIPE_LAT register stages before its pose enters the
// output queue. Throughput: one twist per cycle while the queue has room. The
// depth is set by the sine/cosine pipeline (12 stages) and by the two
// restoring dividers, which resolve one quotient bit per stage (33 stages).
//
// Results collect in a two-entry output queue. While it has room the whole
// pipeline advances and twist_ready is high; when the receiver stalls and the
// queue is full, every stage holds its item and twist_ready drops.
//
// Reset clears the valid bits and the queue; the block then takes a twist in
// the first cycle.
module se2_twist_integrator #(
    parameter int FRAC_BITS = se2ti_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               twist_valid,
    output logic               twist_ready,
    input  se2ti_pkg::twist_t  twist,
    output logic               pose_valid,
    input  logic               pose_ready,
    output se2ti_pkg::pose_t   pose
);
    import se2ti_pkg::*;

    localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE_60DB_9391_054A;
    localparam logic [63:0] PHASE_K =
        64'((65'(INV_TWO_PI_Q64) + (65'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
    localparam logic [31:0] PHASE_K_LO = PHASE_K[31:0];
    localparam logic [31:0] PHASE_K_HI = PHASE_K[63:32];

    localparam int SC_TAP  = 1 + SC_LAT;
    localparam int NUM_TAP = 3 + SC_LAT;
    localparam int LAST    = PIPE_LAT - 1;

    localparam logic [1:0]  QUEUE_FULL = 2'd2;
    localparam logic signed [32:0] TRIG_ONE = 33'sh0_4000_0000;

    logic                en;
    logic [LAST:0]       valid_reg;
    twist_t              side_reg [0:LAST];

    logic [31:0]         pll_hi_reg, plh_lo_reg, phl_lo_reg;
    logic [31:0]         phase_reg;
    logic signed [31:0]  sin_q30, cos_q30;
    logic [63:0]         px_s_reg, px_c_reg, py_c_reg, py_s_reg;
    logic [63:0]         num_x_reg, num_y_reg;
    logic signed [WORD_BITS-1:0] quo_x, quo_y;

    logic [63:0]         w_ext;
    logic [63:0]         pll, plh, phl;
    logic signed [32:0]  cos_m1, one_mc;
    logic signed [64:0]  m_xs, m_yc, m_xc, m_ys;

    pose_t               result;
    pose_t               queue_reg [2];
    logic                wr_ptr_reg, rd_ptr_reg;
    logic [1:0]          cnt_reg;
    logic                push, pop;

    // The pipeline advances while the output queue has room.
    assign en          = (cnt_reg != QUEUE_FULL);
    assign twist_ready = en;

    // Phase in turns: bits 63:32 of w * K from three partial products.
    assign w_ext = {{(64-WORD_BITS){twist.rate_angular[WORD_BITS-1]}}, twist.rate_angular};
    assign pll   = 64'(w_ext[31:0]) * 64'(PHASE_K_LO);
    assign plh   = 64'(w_ext[31:0]) * 64'(PHASE_K_HI);
    assign phl   = 64'(w_ext[63:32]) * 64'(PHASE_K_LO);

    // Numerator terms from the trig values.
    assign cos_m1 = {cos_q30[31], cos_q30} - TRIG_ONE;
    assign one_mc = TRIG_ONE - {cos_q30[31], cos_q30};
    assign m_xs   = 65'(side_reg[SC_TAP].rate_x) * 65'(sin_q30);
    assign m_yc   = 65'(side_reg[SC_TAP].rate_y) * 65'(cos_m1);
    assign m_xc   = 65'(side_reg[SC_TAP].rate_x) * 65'(one_mc);
    assign m_ys   = 65'(side_reg[SC_TAP].rate_y) * 65'(sin_q30);

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[LAST-1:0], twist_valid};
        end
    end

    // Datapath stages outside the trig unit and the dividers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= twist;
            for (int k = 1; k <= LAST; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            pll_hi_reg <= pll[63:32];
            plh_lo_reg <= plh[31:0];
            phl_lo_reg <= phl[31:0];
            phase_reg  <= pll_hi_reg + plh_lo_reg + phl_lo_reg;
            px_s_reg   <= m_xs[63:0];
            px_c_reg   <= m_xc[63:0];
            py_c_reg   <= m_yc[63:0];
            py_s_reg   <= m_ys[63:0];
            num_x_reg  <= px_s_reg + py_c_reg;
            num_y_reg  <= px_c_reg + py_s_reg;
        end
    end

    se2ti_sincos u_sincos (
        .clk     (clk),
        .en      (en),
        .phase   (phase_reg),
        .sin_q30 (sin_q30),
        .cos_q30 (cos_q30)
    );

    se2ti_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
        .clk  (clk),
        .en   (en),
        .num  (num_x_reg),
        .rate (side_reg[NUM_TAP].rate_angular),
        .quo  (quo_x)
    );

    se2ti_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
        .clk  (clk),
        .en   (en),
        .num  (num_y_reg),
        .rate (side_reg[NUM_TAP].rate_angular),
        .quo  (quo_y)
    );

    // A zero angular rate is a pure translation.
    always_comb
    begin
        if (side_reg[LAST].rate_angular == '0)
        begin
            result.disp_x     = side_reg[LAST].rate_x;
            result.disp_y     = side_reg[LAST].rate_y;
            result.disp_angle = '0;
        end
        else
        begin
            result.disp_x     = quo_x;
            result.disp_y     = quo_y;
            result.disp_angle = side_reg[LAST].rate_angular;
        end
    end

    // Two-entry output queue.
    assign push       = en && valid_reg[LAST];
    assign pop        = pose_valid && pose_ready;
    assign pose_valid = (cnt_reg != 2'd0);
    assign pose       = queue_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= result;
        end
    end

endmodule

// File: hdl/se2ti_check.sv
module se2ti_check (
    input logic              clk,
    input logic              rst_n,
    input logic              twist_valid,
    input logic              twist_ready,
    input se2ti_pkg::twist_t twist,
    input logic              pose_valid,
    input logic              pose_ready,
    input se2ti_pkg::pose_t  pose
);
    import se2ti_pkg::*;

    // A waiting pose holds until its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pose_valid && !pose_ready) |=> (pose_valid && $stable(pose)))
    else $error("pose dropped or changed while stalled");

    // Input back-pressure only appears while results wait.
    assert property (@(posedge clk) disable iff (!rst_n)
        !twist_ready |-> pose_valid)
    else $error("twist_ready low with no pose waiting");

    // With the queue full and no pose taken, the input stays blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!twist_ready && !pose_ready) |=> !twist_ready)
    else $error("twist_ready rose without a pose transfer");

    // A pose transfer frees room for the next twist.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pose_valid && pose_ready) |=> twist_ready)
    else $error("twist_ready low after a pose transfer");

endmodule

bind se2_twist_integrator se2ti_check u_check (.*);

// File: sim/se2_pose_checker.sv
`timescale 1ns / 100ps

module se2_pose_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               twist_valid,
    input  logic               twist_ready,
    input  se2ti_pkg::twist_t  twist,
    input  logic               pose_valid,
    input  logic               pose_ready,
    input  se2ti_pkg::pose_t   pose,
    output int                 fail_count,
    output int                 pending
);
    import se2ti_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam logic [63:0] TURN_GAIN = 64'h28BE60DB9391054A;
    localparam logic [63:0] HALF_PI_Q30 = 64'h6487ED51;
    localparam logic [63:0] ONE_Q30 = 64'd1 << TRIG_BITS;

    pose_t expected_poses[$];

    // Sine and cosine of a phase in Q32 turns, both in Q2.30.
    task automatic turn_sincos(input logic [31:0] phase, output logic [63:0] sn,
                               output logic [63:0] cs);
        logic [63:0] p, d, u, a, a2, t, sv, cv, s, c;
        logic [1:0] quad;
        logic neg;
        p = {32'd0, phase};
        quad = 2'((p + (64'd1 << 29)) >> 30);
        d = (p - ({62'd0, quad} << 30)) & 64'hFFFF_FFFF;
        neg = d >= 64'h8000_0000;
        u = neg ? (64'h1_0000_0000 - d) : d;
        a = (u * HALF_PI_Q30 + (64'd1 << 29)) >> 30;
        a2 = (a * a) >> 30;
        t = ONE_Q30 - a2 / 72;
        t = ONE_Q30 - ((a2 * t) >> 30) / 42;
        t = ONE_Q30 - ((a2 * t) >> 30) / 20;
        t = ONE_Q30 - ((a2 * t) >> 30) / 6;
        sv = (a * t) >> 30;
        t = ONE_Q30 - a2 / 90;
        t = ONE_Q30 - ((a2 * t) >> 30) / 56;
        t = ONE_Q30 - ((a2 * t) >> 30) / 30;
        t = ONE_Q30 - ((a2 * t) >> 30) / 12;
        cv = ONE_Q30 - ((a2 * t) >> 30) / 2;
        s = neg ? -sv : sv;
        c = cv;
        case (quad)
            2'd0:
            begin
                sn = s;
                cs = c;
            end
            2'd1:
            begin
                sn = c;
                cs = -s;
            end
            2'd2:
            begin
                sn = -s;
                cs = -c;
            end
            default:
            begin
                sn = -c;
                cs = s;
            end
        endcase
    endtask

    // Rounded quotient with ties away from zero, saturated to the word.
    function automatic logic [31:0] sat_quotient(input logic [63:0] num,
                                                 input logic [63:0] w);
        logic nneg, wneg;
        logic [63:0] nm, wm, den, q, maxp;
        nneg = num[63];
        wneg = w[63];
        nm = nneg ? -num : num;
        wm = wneg ? -w : w;
        den = wm << (TRIG_BITS - FRAC);
        maxp = (64'd1 << (WORD_BITS - 1)) - 1;
        if (den == 0)
            return 32'd0;
        q = (nm + den / 2) / den;
        if (nneg == wneg)
            return (q > maxp) ? maxp[31:0] : q[31:0];
        if (q > maxp + 1)
            q = maxp + 1;
        return 32'(-q);
    endfunction

    // Displacement produced by one twist held for unit time.
    task automatic predict_pose(input twist_t tw, output pose_t ps);
        logic [63:0] w, vx, vy, gain, sn, cs, nx, ny;
        w = 64'(tw.rate_angular);
        vx = 64'(tw.rate_x);
        vy = 64'(tw.rate_y);
        ps.disp_angle = tw.rate_angular;
        if (tw.rate_angular == 0)
        begin
            ps.disp_x = tw.rate_x;
            ps.disp_y = tw.rate_y;
            ps.disp_angle = '0;
        end
        else
        begin
            gain = (TURN_GAIN + (64'd1 << (FRAC - 1))) >> FRAC;
            turn_sincos(32'((w * gain) >> 32), sn, cs);
            nx = vx * sn + vy * (cs - ONE_Q30);
            ny = vx * (ONE_Q30 - cs) + vy * sn;
            ps.disp_x = sat_quotient(nx, w);
            ps.disp_y = sat_quotient(ny, w);
        end
    endtask

    assign pending = expected_poses.size();

    // Predict on each twist transfer; compare on each pose transfer.
    always @(posedge clk)
    begin
        pose_t pred, want;
        if (rst_n && twist_valid && twist_ready)
        begin
            predict_pose(twist, pred);
            expected_poses.push_back(pred);
        end
        if (rst_n && pose_valid && pose_ready)
        begin
            if (expected_poses.size() == 0)
            begin
                $error("pose transfer with no twist outstanding");
                fail_count++;
            end
            else
            begin
                want = expected_poses.pop_front();
                if (pose.disp_x !== want.disp_x)
                begin
                    $error("disp_x expected %0d got %0d", want.disp_x, pose.disp_x);
                    fail_count++;
                end
                if (pose.disp_y !== want.disp_y)
                begin
                    $error("disp_y expected %0d got %0d", want.disp_y, pose.disp_y);
                    fail_count++;
                end
                if (pose.disp_angle !== want.disp_angle)
                begin
                    $error("disp_angle expected %0d got %0d", want.disp_angle,
                           pose.disp_angle);
                    fail_count++;
                end
            end
        end
    end

    initial fail_count = 0;

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import se2ti_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_TWISTS = 650;

    logic   clk;
    logic   rst_n;
    logic   twist_valid;
    logic   twist_ready;
    twist_t twist;
    logic   pose_valid;
    logic   pose_ready;
    pose_t  pose;
    int     fail_count;
    int     pending;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_off;
    int     quiet_cycles;

    se2_twist_integrator i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .twist_valid (twist_valid),
        .twist_ready (twist_ready),
        .twist       (twist),
        .pose_valid  (pose_valid),
        .pose_ready  (pose_ready),
        .pose        (pose)
    );

    se2_pose_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .twist_valid (twist_valid),
        .twist_ready (twist_ready),
        .twist       (twist),
        .pose_valid  (pose_valid),
        .pose_ready  (pose_ready),
        .pose        (pose),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Random 32-bit word, biased toward extremes, small magnitudes and zero.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return 32'($signed($urandom_range(0, 4000)) - 2000);
            3: return 32'd0;
            4: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
            default: return $urandom();
        endcase
    endfunction

    // Offer one twist and hold it until the transfer; random gaps before it.
    // Valid drops only while idling, so back-to-back twists keep it high.
    task automatic send_twist(input logic [31:0] w, input logic [31:0] vx,
                              input logic [31:0] vy);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            twist_valid <= 1'b0;
            @(negedge clk);
        end
        twist_valid <= 1'b1;
        twist <= '{rate_angular: w, rate_x: vx, rate_y: vy};
        @(posedge clk);
        while (!twist_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        pose_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                pose_ready <= 1'b0;
                hold_off--;
            end
            else
            begin
                pose_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: cycles without any transfer.
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((twist_valid && twist_ready) || (pose_valid && pose_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0] sw;
        rst_n = 1'b0;
        twist_valid = 1'b0;
        twist = '0;
        send_idle_pct = 33;
        recv_idle_pct = 64;
        hold_off = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero rate, extremes, quadrant edges, tiny rate overflow.
        send_twist(32'd0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_twist(32'd0, 32'd0, 32'd0);
        send_twist(32'h0001_0000, 32'h0001_0000, 32'd0);
        send_twist(32'hFFFF_0000, 32'd0, 32'h0001_0000);
        send_twist(32'h0001_921F, 32'h0002_0000, 32'hFFFE_0000);
        send_twist(32'h0003_243F, 32'h0001_0000, 32'h0001_0000);
        send_twist(32'h0004_B65F, 32'hFFFF_0000, 32'h0003_0000);
        send_twist(32'h0006_487F, 32'h0001_0000, 32'h0001_0000);
        send_twist(32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_twist(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_twist(32'd1, 32'h8000_0000, 32'h8000_0000);
        send_twist(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_twist(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_twist(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_twist(32'h0064_0000, 32'h0010_0000, 32'hFFF0_0000);
        send_twist(32'hFF9C_0000, 32'hAAAA_AAAA, 32'h5555_5555);
        send_twist(32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA);
        send_twist(32'h0000_8000, 32'h0001_0000, 32'h0000_0001);

        // Long receiver hold-off while the sender keeps offering twists.
        send_idle_pct = 0;
        hold_off = 150;
        for (int i = 0; i < 80; i++)
            send_twist(pick_word(), pick_word(), pick_word());
        send_idle_pct = 33;

        for (int i = 0; i < RANDOM_TWISTS; i++)
        begin
            if (i == RANDOM_TWISTS / 3)
            begin
                send_idle_pct = 64;
                recv_idle_pct = 33;
            end
            else if (i == 2 * RANDOM_TWISTS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            sw = pick_word();
            send_twist(sw, pick_word(), pick_word());
        end
        twist_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 10) @(posedge clk);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
